// ----- rtl/dda_line_rasterizer_unit_macros.svh -----
// Assertion helpers for the rasterizer sequencer, the only module that uses them.
`ifndef DDA_LINE_RASTERIZER_UNIT_MACROS_SVH
`define DDA_LINE_RASTERIZER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define DDA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define DDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ----- rtl/dda_lr_pkg.sv -----
package dda_lr_pkg;

   localparam int COORD_BITS   = 6;
   localparam int FRAC_BITS    = 16;
   localparam int COLOUR_BITS  = 24;

   // Position accumulator: integer part above FRAC_BITS fraction bits.
   localparam int POS_BITS     = COORD_BITS + FRAC_BITS;
   // Increment magnitude is at most 1.0, so one integer bit is enough.
   localparam int QUO_BITS     = FRAC_BITS + 1;
   // Signed increment: magnitude plus sign.
   localparam int INC_BITS     = FRAC_BITS + 2;
   // Partial remainder holds up to twice the step count.
   localparam int REM_BITS     = COORD_BITS + 1;
   localparam int DIV_CNT_BITS = $clog2(FRAC_BITS + 1);

   typedef struct packed {
      logic load;
      logic div_step;
      logic emit;
   } dda_lr_cmd_type;

   typedef struct packed {
      logic steps_zero;
      logic div_done;
      logic at_end;
      logic out_free;
   } dda_lr_sts_type;

endpackage

// ----- rtl/dda_lr_ctrl.sv -----
`include "dda_line_rasterizer_unit_macros.svh"

module dda_lr_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  dda_lr_pkg::dda_lr_sts_type sts,
   output dda_lr_pkg::dda_lr_cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.div_step = 1'b0;
      cmd.emit     = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done || sts.steps_zero) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               if (sts.at_end) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `DDA_ASSERT_NOW(a_emit_needs_room, clock, reset, cmd.emit, sts.out_free)
   `DDA_ASSERT_NEXT(a_accept_starts_div, clock, reset, req_valid && req_ready, state_ff == ST_DIV)
   `DDA_ASSERT_NEXT(a_last_emit_ends, clock, reset, cmd.emit && sts.at_end, req_ready)
   `DDA_ASSERT_NEXT(a_div_holds, clock, reset, (state_ff == ST_DIV) && !sts.div_done && !sts.steps_zero, state_ff == ST_DIV)

endmodule

// ----- rtl/dda_lr_datapath.sv -----
module dda_lr_datapath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic [dda_lr_pkg::COORD_BITS-1:0]       req_x_start,
   input  logic [dda_lr_pkg::COORD_BITS-1:0]       req_y_start,
   input  logic [dda_lr_pkg::COORD_BITS-1:0]       req_x_end,
   input  logic [dda_lr_pkg::COORD_BITS-1:0]       req_y_end,
   input  logic [dda_lr_pkg::COLOUR_BITS-1:0]      req_colour,
   input  logic                                    rsp_ready,
   output logic                                    rsp_valid,
   output logic [dda_lr_pkg::COORD_BITS-1:0]       rsp_pixel_x,
   output logic [dda_lr_pkg::COORD_BITS-1:0]       rsp_pixel_y,
   output logic [dda_lr_pkg::COLOUR_BITS-1:0]      rsp_pixel_colour,
   output logic                                    rsp_last_pixel,
   input  dda_lr_pkg::dda_lr_cmd_type              cmd,
   output dda_lr_pkg::dda_lr_sts_type              sts
);

   localparam int CB = dda_lr_pkg::COORD_BITS;
   localparam int FB = dda_lr_pkg::FRAC_BITS;
   localparam int PB = dda_lr_pkg::POS_BITS;
   localparam int QB = dda_lr_pkg::QUO_BITS;
   localparam int IB = dda_lr_pkg::INC_BITS;
   localparam int RB = dda_lr_pkg::REM_BITS;
   localparam int DB = dda_lr_pkg::DIV_CNT_BITS;

   // Line setup from the request.
   logic [CB:0]   diff_x;
   logic [CB:0]   diff_y;
   logic [CB:0]   mag_x;
   logic [CB:0]   mag_y;
   logic [CB-1:0] abs_x;
   logic [CB-1:0] abs_y;
   logic [CB-1:0] steps_calc;

   // Stored line state.
   logic [CB-1:0] steps_ff, x_end_ff, y_end_ff, pix_cnt_ff, pix_cnt_in;
   logic [dda_lr_pkg::COLOUR_BITS-1:0] colour_ff;
   logic          neg_x_ff, neg_y_ff;
   logic [PB-1:0] pos_x_ff, pos_y_ff, pos_x_in, pos_y_in;
   logic [RB-1:0] rem_x_ff, rem_y_ff, rem_x_in, rem_y_in;
   logic [QB-1:0] quo_x_ff, quo_y_ff, quo_x_in, quo_y_in;
   logic [DB-1:0] div_cnt_ff, div_cnt_in;

   // Divider step.
   logic [RB-1:0] trial_x, trial_y, divisor;
   logic          ge_x, ge_y;

   // Increments.
   logic [IB-1:0] inc_x, inc_y;

   // Output register.
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [CB-1:0]                       rsp_x_ff, rsp_y_ff;
   logic [dda_lr_pkg::COLOUR_BITS-1:0]  rsp_colour_ff;
   logic                                rsp_last_ff;

   always_comb begin
      diff_x     = {1'b0, req_x_end} - {1'b0, req_x_start};
      diff_y     = {1'b0, req_y_end} - {1'b0, req_y_start};
      mag_x      = diff_x[CB] ? (~diff_x + 1'b1) : diff_x;
      mag_y      = diff_y[CB] ? (~diff_y + 1'b1) : diff_y;
      abs_x      = mag_x[CB-1:0];
      abs_y      = mag_y[CB-1:0];
      steps_calc = (abs_y > abs_x) ? abs_y : abs_x;
   end

   // Restoring division, one quotient bit per cycle for both axes. The first
   // step produces the integer bit from the span itself.
   always_comb begin
      divisor  = {1'b0, steps_ff};
      trial_x  = (div_cnt_ff == '0) ? rem_x_ff : {rem_x_ff[RB-2:0], 1'b0};
      trial_y  = (div_cnt_ff == '0) ? rem_y_ff : {rem_y_ff[RB-2:0], 1'b0};
      ge_x     = (trial_x >= divisor);
      ge_y     = (trial_y >= divisor);
      rem_x_in = ge_x ? (trial_x - divisor) : trial_x;
      rem_y_in = ge_y ? (trial_y - divisor) : trial_y;
      quo_x_in = {quo_x_ff[QB-2:0], ge_x};
      quo_y_in = {quo_y_ff[QB-2:0], ge_y};
      div_cnt_in = div_cnt_ff + 1'b1;
   end

   always_comb begin
      inc_x      = neg_x_ff ? (~{1'b0, quo_x_ff} + 1'b1) : {1'b0, quo_x_ff};
      inc_y      = neg_y_ff ? (~{1'b0, quo_y_ff} + 1'b1) : {1'b0, quo_y_ff};
      pos_x_in   = pos_x_ff + PB'(signed'(inc_x));
      pos_y_in   = pos_y_ff + PB'(signed'(inc_y));
      pix_cnt_in = pix_cnt_ff + 1'b1;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         steps_ff   <= steps_calc;
         x_end_ff   <= req_x_end;
         y_end_ff   <= req_y_end;
         colour_ff  <= req_colour;
         neg_x_ff   <= diff_x[CB];
         neg_y_ff   <= diff_y[CB];
         pos_x_ff   <= {req_x_start, {FB{1'b0}}};
         pos_y_ff   <= {req_y_start, {FB{1'b0}}};
         rem_x_ff   <= {1'b0, abs_x};
         rem_y_ff   <= {1'b0, abs_y};
         quo_x_ff   <= '0;
         quo_y_ff   <= '0;
         div_cnt_ff <= '0;
         pix_cnt_ff <= '0;
      end else begin
         if (cmd.div_step) begin
            rem_x_ff   <= rem_x_in;
            rem_y_ff   <= rem_y_in;
            quo_x_ff   <= quo_x_in;
            quo_y_ff   <= quo_y_in;
            div_cnt_ff <= div_cnt_in;
         end
         if (cmd.emit) begin
            pos_x_ff   <= pos_x_in;
            pos_y_ff   <= pos_y_in;
            pix_cnt_ff <= pix_cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_x_ff      <= sts.at_end ? x_end_ff : pos_x_ff[PB-1:FB];
         rsp_y_ff      <= sts.at_end ? y_end_ff : pos_y_ff[PB-1:FB];
         rsp_colour_ff <= colour_ff;
         rsp_last_ff   <= sts.at_end;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      sts.steps_zero = (steps_ff == '0);
      sts.div_done   = (div_cnt_ff == DB'(FB));
      sts.at_end     = (pix_cnt_ff == steps_ff);
      sts.out_free   = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_pixel_x      = rsp_x_ff;
   assign rsp_pixel_y      = rsp_y_ff;
   assign rsp_pixel_colour = rsp_colour_ff;
   assign rsp_last_pixel   = rsp_last_ff;

endmodule

// ----- rtl/dda_line_rasterizer_unit.sv -----
// DDA line rasterizer. A request carries two endpoints on a 64 by 64 grid
// and a 24-bit colour; the block answers with one response per pixel of the
// line from the start point to the end point inclusive, the final pixel
// flagged by rsp_last_pixel and always placed exactly on the end point.
// Equal endpoints give a single pixel. A request is handled on its own, one
// at a time: it is captured, a bit-serial restoring divider forms both
// per-axis increments (16 fraction bits plus the integer bit), then one
// pixel per cycle is issued while the response side keeps up, steps + 1
// pixels where steps is the larger axis span. A new request is taken as
// soon as the last pixel sits in the output register, even while it waits
// to be taken.
module dda_line_rasterizer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [dda_lr_pkg::COORD_BITS-1:0]   req_x_start,
   input  logic [dda_lr_pkg::COORD_BITS-1:0]   req_y_start,
   input  logic [dda_lr_pkg::COORD_BITS-1:0]   req_x_end,
   input  logic [dda_lr_pkg::COORD_BITS-1:0]   req_y_end,
   input  logic [dda_lr_pkg::COLOUR_BITS-1:0]  req_colour,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [dda_lr_pkg::COORD_BITS-1:0]   rsp_pixel_x,
   output logic [dda_lr_pkg::COORD_BITS-1:0]   rsp_pixel_y,
   output logic [dda_lr_pkg::COLOUR_BITS-1:0]  rsp_pixel_colour,
   output logic                                rsp_last_pixel
);

   // Commands from the sequencer and status back from the datapath.
   dda_lr_pkg::dda_lr_cmd_type cmd;
   dda_lr_pkg::dda_lr_sts_type sts;

   // The sequencer walks idle, divide and emit; it only issues a pixel when
   // the output register is free or being drained in the same cycle.
   dda_lr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the line setup, the two dividers, the position
   // accumulators and the response register.
   dda_lr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_x_start      (req_x_start),
      .req_y_start      (req_y_start),
      .req_x_end        (req_x_end),
      .req_y_end        (req_y_end),
      .req_colour       (req_colour),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_colour (rsp_pixel_colour),
      .rsp_last_pixel   (rsp_last_pixel),
      .cmd              (cmd),
      .sts              (sts)
   );

endmodule

// ----- bench/tb_dda_line_rasterizer_unit.sv -----
module tb_dda_line_rasterizer_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_BITS  = dda_lr_pkg::COORD_BITS;
   localparam int COLOUR_BITS = dda_lr_pkg::COLOUR_BITS;
   localparam int FRAC_BITS   = dda_lr_pkg::FRAC_BITS;

   // With no handshake at all, the longest quiet stretch a healthy run can
   // show is the long response hold-off plus one stall, one request gap and
   // the divider. The watchdog limit is several times that.
   localparam int HOLD_OFF_CYCLES   = 400;
   localparam int WATCHDOG_LIMIT    = 3000;
   localparam int END_SETTLE_CYCLES = 120;
   localparam int RANDOM_LINES      = 460;
   localparam int MAX_PRINTED       = 40;

   // One line request as the stimulus queue holds it. The gap is the number
   // of idle cycles the sender leaves after this request is taken. When
   // drain_first is set, the sender holds the request back until every
   // pixel it expects has arrived.
   typedef struct {
      logic [COORD_BITS-1:0]  x_start;
      logic [COORD_BITS-1:0]  y_start;
      logic [COORD_BITS-1:0]  x_end;
      logic [COORD_BITS-1:0]  y_end;
      logic [COLOUR_BITS-1:0] colour;
      int                     gap;
      bit                     drain_first;
   } line_request_type;

   typedef struct {
      logic [COORD_BITS-1:0]  x;
      logic [COORD_BITS-1:0]  y;
      logic [COLOUR_BITS-1:0] colour;
      logic                   last;
   } pixel_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [COORD_BITS-1:0]  req_x_start = '0;
   logic [COORD_BITS-1:0]  req_y_start = '0;
   logic [COORD_BITS-1:0]  req_x_end = '0;
   logic [COORD_BITS-1:0]  req_y_end = '0;
   logic [COLOUR_BITS-1:0] req_colour = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [COORD_BITS-1:0]  rsp_pixel_x;
   logic [COORD_BITS-1:0]  rsp_pixel_y;
   logic [COLOUR_BITS-1:0] rsp_pixel_colour;
   logic                   rsp_last_pixel;

   line_request_type pending_lines[$];
   pixel_type        expected_pixels[$];

   // Handshake flags captured at the rising edge and read by the processes
   // that drive the inputs at the following falling edge.
   logic request_taken = 1'b0;
   logic pixel_taken = 1'b0;

   int  fail_count = 0;
   int  quiet_cycles = 0;
   bit  sender_calm = 1'b0;
   bit  drain_next = 1'b0;

   dda_line_rasterizer_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_x_start      (req_x_start),
      .req_y_start      (req_y_start),
      .req_x_end        (req_x_end),
      .req_y_end        (req_y_end),
      .req_colour       (req_colour),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_pixel_x      (rsp_pixel_x),
      .rsp_pixel_y      (rsp_pixel_y),
      .rsp_pixel_colour (rsp_pixel_colour),
      .rsp_last_pixel   (rsp_last_pixel)
   );

   initial forever #2 clock = ~clock;

   // Every mismatch goes through here. The printout is capped so that a
   // badly broken design cannot flood the log, but every failure is counted.
   task automatic report_mismatch(input string what, input longint got,
                                  input longint want);
      fail_count++;
      if (fail_count <= MAX_PRINTED) begin
         $display("mismatch at %0t: %s, got 0x%0h, expected 0x%0h",
                  $realtime, what, got, want);
      end
   endtask

   // Works out every pixel of one line and appends them to the queue of
   // expected pixels. The step count is the larger axis span. Each axis
   // increment is span / steps in signed fixed point with FRAC_BITS
   // fraction bits, truncated toward zero, which SystemVerilog division of
   // signed operands already does. The position starts on the start point
   // with a zero fraction, each pixel takes the integer part, and the final
   // pixel is placed exactly on the end point.
   function automatic void rasterize_line(input logic [COORD_BITS-1:0] xs,
                                          input logic [COORD_BITS-1:0] ys,
                                          input logic [COORD_BITS-1:0] xe,
                                          input logic [COORD_BITS-1:0] ye,
                                          input logic [COLOUR_BITS-1:0] colour);
      longint dx, dy, steps, inc_x, inc_y, pos_x, pos_y;
      pixel_type p;
      dx = longint'(xe) - longint'(xs);
      dy = longint'(ye) - longint'(ys);
      steps = (dx < 0) ? -dx : dx;
      if (dy > steps) steps = dy;
      if (-dy > steps) steps = -dy;
      p.colour = colour;
      if (steps != 0) begin
         inc_x = (dx * (longint'(1) <<< FRAC_BITS)) / steps;
         inc_y = (dy * (longint'(1) <<< FRAC_BITS)) / steps;
         pos_x = longint'(xs) <<< FRAC_BITS;
         pos_y = longint'(ys) <<< FRAC_BITS;
         p.last = 1'b0;
         for (longint i = 0; i < steps; i++) begin
            // Truncation keeps the positions between the endpoints, so the
            // integer part is never negative and fits the coordinate width.
            p.x = COORD_BITS'(pos_x >>> FRAC_BITS);
            p.y = COORD_BITS'(pos_y >>> FRAC_BITS);
            expected_pixels.push_back(p);
            pos_x += inc_x;
            pos_y += inc_y;
         end
      end
      // Equal endpoints fall through to here with no pixels before it, so
      // the single pixel sits on the start point, which is the end point.
      p.x = xe;
      p.y = ye;
      p.last = 1'b1;
      expected_pixels.push_back(p);
   endfunction

   // Queues one line request. The idle gap after it is drawn here: none in
   // a calm stretch, a randomly drawn one otherwise.
   task automatic add_line(input int xs, input int ys, input int xe, input int ye,
                           input logic [COLOUR_BITS-1:0] colour);
      line_request_type r;
      r.x_start = COORD_BITS'(xs);
      r.y_start = COORD_BITS'(ys);
      r.x_end = COORD_BITS'(xe);
      r.y_end = COORD_BITS'(ye);
      r.colour = colour;
      r.gap = sender_calm ? 0 : $urandom_range(0, 15);
      r.drain_first = drain_next;
      drain_next = 1'b0;
      pending_lines.push_back(r);
   endtask

   // Stimulus and end of run. Reset is held high at first and then released
   // for good at a falling edge. The directed lines come first, then the
   // random ones. Once everything is sent the block drains, settles, and
   // the verdict is printed.
   initial begin
      int xs, ys, xe, ye, lo, hi, kind;
      logic [COLOUR_BITS-1:0] colour;

      // Equal endpoints at two opposite corners of the grid.
      add_line(0, 0, 0, 0, 24'h000000);
      add_line(63, 63, 63, 63, 24'hFFFFFF);
      // Full-length horizontal, vertical and diagonal lines, both ways.
      add_line(0, 0, 63, 0, 24'hAAAAAA);
      add_line(63, 0, 0, 0, 24'h555555);
      add_line(0, 0, 0, 63, 24'h800000);
      add_line(0, 63, 0, 0, 24'h000001);
      add_line(0, 0, 63, 63, 24'h123456);
      add_line(63, 63, 0, 0, 24'hFEDCBA);
      add_line(63, 0, 0, 63, 24'h0F0F0F);
      add_line(0, 63, 63, 0, 24'hF0F0F0);
      // Nearly flat, steep and diagonal lines, where the fraction matters most, and an inner diagonal.
      add_line(0, 0, 63, 1, 24'h7FFFFF);
      add_line(0, 0, 1, 63, 24'hFFFFFE);
      add_line(63, 63, 62, 0, 24'h00FF00);
      add_line(0, 0, 63, 62, 24'h0000FF);
      add_line(62, 1, 1, 62, 24'hFF0000);
      // Two-pixel lines and a few lines of general slope.
      add_line(10, 20, 11, 20, 24'h3C3C3C);
      add_line(20, 10, 20, 9, 24'hC3C3C3);
      add_line(5, 7, 45, 22, 24'h6699CC);
      add_line(40, 3, 17, 60, 24'h996633);
      add_line(33, 33, 31, 60, 24'h10E1D0);

      // The first random line waits for the directed part to drain.
      drain_next = 1'b1;
      for (int n = 0; n < RANDOM_LINES; n++) begin
         if (n % 32 == 0) sender_calm = ($urandom_range(0, 3) == 0);
         // A second full drain in the middle of the random part.
         if (n == RANDOM_LINES / 2) drain_next = 1'b1;
         colour = COLOUR_BITS'($urandom);
         xs = $urandom_range(0, 63);
         ys = $urandom_range(0, 63);
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            xe = xs;
            ye = ys;
         end else if (kind <= 3) begin
            // Short lines keep the run brisk and stress back-to-back lines.
            lo = (xs < 6) ? 0 : xs - 6;
            hi = (xs > 57) ? 63 : xs + 6;
            xe = $urandom_range(lo, hi);
            lo = (ys < 6) ? 0 : ys - 6;
            hi = (ys > 57) ? 63 : ys + 6;
            ye = $urandom_range(lo, hi);
         end else if (kind == 4) begin
            // Horizontal, vertical or exact diagonal lines.
            xe = $urandom_range(0, 63);
            case ($urandom_range(0, 2))
               0: ye = ys;
               1: begin
                  ye = xe;
                  xe = xs;
               end
               default: begin
                  lo = (xe > xs) ? xe - xs : xs - xe;
                  ye = (ys + lo <= 63) ? ys + lo : ys - lo;
                  if (ye < 0) ye = ys;
                  if (ye == ys) xe = xs;
               end
            endcase
         end else begin
            xe = $urandom_range(0, 63);
            ye = $urandom_range(0, 63);
         end
         add_line(xs, ys, xe, ye, colour);
      end

      repeat (11) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (pending_lines.size() != 0 || req_valid) @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (END_SETTLE_CYCLES) @(posedge clock);
      if (expected_pixels.size() != 0) begin
         report_mismatch("pixels never delivered", 0, expected_pixels.size());
      end
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Request driver. A request on offer is held, payload unchanged, until
   // it is taken. After that the sender idles for the gap drawn for that
   // request and then offers the next one from the queue. A request marked
   // to wait for the drain is not offered while any pixel is outstanding.
   int idle_left = 0;

   always @(negedge clock) begin
      line_request_type r;
      if (reset) begin
         req_valid <= 1'b0;
         idle_left = 0;
      end else if (req_valid && !request_taken) begin
         // Still on offer: keep everything as it is.
      end else if (idle_left > 0) begin
         idle_left--;
         req_valid <= 1'b0;
      end else if (pending_lines.size() != 0 &&
                   !(pending_lines[0].drain_first && expected_pixels.size() != 0)) begin
         r = pending_lines.pop_front();
         req_x_start <= r.x_start;
         req_y_start <= r.y_start;
         req_x_end <= r.x_end;
         req_y_end <= r.y_end;
         req_colour <= r.colour;
         req_valid <= 1'b1;
         idle_left = r.gap;
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Pixel receiver. After each pixel taken it stalls for a randomly drawn
   // length, or not at all during a calm stretch. Once, well into the run, it refuses
   // pixels for a long hold-off while the sender keeps offering requests,
   // so the block backs up and has to stall its request side.
   int  stall_left = 0;
   int  hold_left = 0;
   int  pixels_seen = 0;
   bit  receiver_calm = 1'b0;

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (pixel_taken) begin
            pixels_seen++;
            if (pixels_seen % 64 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
            stall_left = receiver_calm ? 0 : $urandom_range(0, 15);
            if (pixels_seen == 1500) hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Monitor. Every pixel taken is compared field by field with the oldest
   // expected pixel. Every request taken has its pixels predicted and queued
   // behind those of earlier lines. The check comes first, so a pixel taken
   // at the same edge as a new request is matched against older lines.
   always @(posedge clock) begin
      pixel_type want;
      request_taken <= !reset && req_valid && req_ready;
      pixel_taken <= !reset && rsp_valid && rsp_ready;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_pixels.size() == 0) begin
               report_mismatch("pixel with no line outstanding, x", rsp_pixel_x, 0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_x !== want.x)
                  report_mismatch("pixel_x", rsp_pixel_x, want.x);
               if (rsp_pixel_y !== want.y)
                  report_mismatch("pixel_y", rsp_pixel_y, want.y);
               if (rsp_pixel_colour !== want.colour)
                  report_mismatch("pixel_colour", rsp_pixel_colour, want.colour);
               if (rsp_last_pixel !== want.last)
                  report_mismatch("last_pixel", rsp_last_pixel, want.last);
            end
         end
         if (req_valid && req_ready) begin
            rasterize_line(req_x_start, req_y_start, req_x_end, req_y_end, req_colour);
         end
      end
   end

   // Watchdog. It counts cycles in which neither side completes a handshake
   // and ends the run as a failure when the count reaches the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
